// ----- rtl/dpc_pkg.sv -----
// Shared types, widths and constants of the dosing pump controller.
`timescale 1ns / 1ps

package dpc_pkg;

  localparam int FLOW_W    = 14;
  localparam int RUNTIME_W = 19;
  localparam int VOL_W     = 17;
  localparam int RATE_W    = 14;
  localparam int ELAPSED_W = 19;
  localparam int RUNVOL_W  = 22;
  localparam int TOTAL_W   = 40;
  localparam int COUNT_W   = 32;
  localparam int PROD_W    = ELAPSED_W + FLOW_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 19;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 160;

  localparam int MS_PER_S = 1000;

  localparam logic [FLOW_W-1:0]    FLOW_RATE_RST   = 14'd4000;
  localparam logic [RUNTIME_W-1:0] MAX_RUNTIME_RST = 19'd60000;
  localparam logic                 RELAY_INV_RST   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUNTIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_INV   = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_DOSE  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BUSY       = 2'd1,
    ST_BAD_VOLUME = 2'd2,
    ST_OVER_LIMIT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_DOSE = 2'd1,
    MODE_CONT = 2'd2
  } mode_t;

endpackage

// ----- rtl/dpc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module dpc_div #(
  parameter int DIVIDEND_W = dpc_pkg::PROD_W,
  parameter int DIVISOR_W  = dpc_pkg::RATE_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIVISOR_W:0] shifted;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = (shifted >= {1'b0, dsr_r});
    rem_nxt = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
        cnt_r  <= CNT_W'(DIVIDEND_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/dosing_pump_controller_core.sv -----
// Top level of the dosing pump controller: command sequencer, state and totals.
`timescale 1ns / 1ps

// The controller takes one command per transfer on the in_ channel: in_tuser
// carries the command (tick, dose, start continuous, stop) and in_tdata the
// dose volume and the optional rate override. Every command produces exactly
// one result transfer on the out_ channel with status, relay pin level, mode,
// elapsed time, run volume and the saturating totals.
// Commands that need arithmetic (a tick or stop while the pump runs, and a
// dose that passes the busy and zero-volume checks) go through one multiplier
// and one shared bit-serial divider: the sequencer steps from S_IDLE through
// S_MUL, S_START, S_DIV and S_UPD to S_OUT. All other commands go straight
// from S_IDLE to S_OUT. In S_OUT out_tvalid is raised as soon as the output
// register is free. The controller works on one command at a time; in_tready
// is high only while the sequencer is idle.
// The result sits in an output register; the next command is accepted while
// it waits. If the receiver stalls, the following result waits in the
// sequencer and no further command is accepted until the register frees up.
// Configuration writes on the cfg_ channel are always accepted and apply at
// once. Reset (synchronous, active low) restores the register defaults, stops
// the pump and clears all totals.

module dosing_pump_controller_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: dose_volume [16:0], rate_override [30:17], zero [31]
  input  logic [dpc_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: cmd [1:0]
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: status [1:0], relay_level [2], pumping [3], mode_out [5:4],
  // elapsed_out [24:6], run_volume [46:25], total_volume [86:47],
  // dose_total [118:87], total_runtime [158:119], dose_finished [159]
  output logic [dpc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import dpc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_START = 6'b000100,
    S_DIV   = 6'b001000,
    S_UPD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [RUNVOL_W-1:0]  RUNVOL_MAX  = '1;
  localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = '1;
  localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [VOL_W-1:0]       vol_r, vol_nxt;
  logic [RATE_W-1:0]      ovr_r, ovr_nxt;

  logic [FLOW_W-1:0]      flow_rate_r;
  logic [RUNTIME_W-1:0]   max_runtime_r;
  logic                   relay_inv_r;

  mode_t                  mode_r, mode_nxt;
  logic                   running_r, running_nxt;
  logic [ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic [ELAPSED_W-1:0]   target_r, target_nxt;
  logic [RUNVOL_W-1:0]    cur_vol_r, cur_vol_nxt;
  logic [TOTAL_W-1:0]     vol_sum_r, vol_sum_nxt;
  logic [COUNT_W-1:0]     dose_cnt_r, dose_cnt_nxt;
  logic [TOTAL_W-1:0]     runtime_sum_r, runtime_sum_nxt;
  status_t                status_r, status_nxt;
  logic                   finished_r, finished_nxt;

  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  logic                   div_start;
  logic [RATE_W-1:0]      div_divisor;
  logic                   div_done;
  logic [PROD_W-1:0]      div_quot;

  logic [RATE_W-1:0]      rate_sel;
  logic [ELAPSED_W-1:0]   mul_a;
  logic [FLOW_W-1:0]      mul_b;
  logic [RUNVOL_W-1:0]    cv_sat;
  logic [TOTAL_W:0]       vsum_add;
  logic [TOTAL_W-1:0]     vsum_sat;
  logic [TOTAL_W:0]       rsum_add;
  logic [TOTAL_W-1:0]     rsum_sat;
  logic [COUNT_W-1:0]     dcnt_inc;
  logic [ELAPSED_W-1:0]   elapsed_vis;
  logic                   in_xfer;
  logic                   out_free;

  dpc_div #(
    .DIVIDEND_W (PROD_W),
    .DIVISOR_W  (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Arithmetic shared by the update step and the multiplier operands.
  always_comb begin
    rate_sel    = (ovr_r != '0) ? ovr_r : flow_rate_r;
    mul_a       = (cmd_r == CMD_DOSE) ? ELAPSED_W'(vol_r) : elapsed_r;
    mul_b       = (cmd_r == CMD_DOSE) ? FLOW_W'(MS_PER_S) : flow_rate_r;
    div_divisor = (cmd_r == CMD_DOSE) ? rate_sel : RATE_W'(MS_PER_S);
    div_start   = (state_r == S_START);
    cv_sat      = (div_quot > PROD_W'(RUNVOL_MAX)) ? RUNVOL_MAX : div_quot[RUNVOL_W-1:0];
    vsum_add    = {1'b0, vol_sum_r} + (TOTAL_W + 1)'(cv_sat);
    vsum_sat    = vsum_add[TOTAL_W] ? TOTAL_MAX : vsum_add[TOTAL_W-1:0];
    rsum_add    = {1'b0, runtime_sum_r} + (TOTAL_W + 1)'(elapsed_r);
    rsum_sat    = rsum_add[TOTAL_W] ? TOTAL_MAX : rsum_add[TOTAL_W-1:0];
    dcnt_inc    = (dose_cnt_r == COUNT_MAX) ? dose_cnt_r : dose_cnt_r + 1'b1;
    elapsed_vis = running_r ? elapsed_r : '0;
    in_xfer     = in_tvalid && (state_r == S_IDLE);
    out_free    = !out_tvalid_r || out_tready;
  end

  // Sequencer and state update.
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    vol_nxt         = vol_r;
    ovr_nxt         = ovr_r;
    mode_nxt        = mode_r;
    running_nxt     = running_r;
    elapsed_nxt     = elapsed_r;
    target_nxt      = target_r;
    cur_vol_nxt     = cur_vol_r;
    vol_sum_nxt     = vol_sum_r;
    dose_cnt_nxt    = dose_cnt_r;
    runtime_sum_nxt = runtime_sum_r;
    status_nxt      = status_r;
    finished_nxt    = finished_r;
    prod_nxt        = prod_r;
    out_tvalid_nxt  = out_tvalid_r;
    out_data_nxt    = out_data_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt      = cmd_t'(in_tuser);
          vol_nxt      = in_tdata[VOL_W-1:0];
          ovr_nxt      = in_tdata[VOL_W +: RATE_W];
          status_nxt   = ST_OK;
          finished_nxt = 1'b0;
          state_nxt    = S_OUT;
          case (cmd_t'(in_tuser))
            CMD_TICK: begin
              if (running_r) begin
                if (elapsed_r != ELAPSED_MAX) begin
                  elapsed_nxt = elapsed_r + 1'b1;
                end
                state_nxt = S_MUL;
              end
            end
            CMD_DOSE: begin
              if (running_r) begin
                status_nxt = ST_BUSY;
              end else if (in_tdata[VOL_W-1:0] == '0) begin
                status_nxt = ST_BAD_VOLUME;
              end else begin
                state_nxt = S_MUL;
              end
            end
            CMD_START: begin
              if (running_r) begin
                status_nxt = ST_BUSY;
              end else begin
                mode_nxt    = MODE_CONT;
                target_nxt  = '0;
                cur_vol_nxt = '0;
                elapsed_nxt = '0;
                running_nxt = 1'b1;
              end
            end
            CMD_STOP: begin
              if (running_r) begin
                state_nxt = S_MUL;
              end
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);
        state_nxt = S_START;
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_DOSE: begin
            // A zero rate gives a zero duration: the dose then runs until
            // stop or the safety limit.
            if ((rate_sel != '0) && (div_quot > PROD_W'(max_runtime_r))) begin
              status_nxt = ST_OVER_LIMIT;
            end else begin
              mode_nxt    = MODE_DOSE;
              target_nxt  = (rate_sel != '0) ? div_quot[ELAPSED_W-1:0] : '0;
              cur_vol_nxt = '0;
              elapsed_nxt = '0;
              running_nxt = 1'b1;
            end
          end
          CMD_STOP: begin
            cur_vol_nxt     = cv_sat;
            vol_sum_nxt     = vsum_sat;
            if (mode_r == MODE_DOSE) begin
              dose_cnt_nxt = dcnt_inc;
            end
            runtime_sum_nxt = rsum_sat;
            running_nxt     = 1'b0;
            mode_nxt        = MODE_IDLE;
            target_nxt      = '0;
          end
          default: begin
            // Tick while running: the safety limit wins over dose completion.
            cur_vol_nxt = cv_sat;
            if (elapsed_r >= max_runtime_r) begin
              runtime_sum_nxt = rsum_sat;
              running_nxt     = 1'b0;
              mode_nxt        = MODE_IDLE;
              target_nxt      = '0;
            end else if ((mode_r == MODE_DOSE) && (target_r != '0) &&
                         (elapsed_r >= target_r)) begin
              vol_sum_nxt     = vsum_sat;
              dose_cnt_nxt    = dcnt_inc;
              runtime_sum_nxt = rsum_sat;
              running_nxt     = 1'b0;
              mode_nxt        = MODE_IDLE;
              target_nxt      = '0;
              finished_nxt    = 1'b1;
            end
          end
        endcase
      end
      S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {finished_r, runtime_sum_r, dose_cnt_r, vol_sum_r, cur_vol_r,
                            elapsed_vis, mode_r, running_r, running_r ^ relay_inv_r,
                            status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cmd_r         <= CMD_TICK;
      flow_rate_r   <= FLOW_RATE_RST;
      max_runtime_r <= MAX_RUNTIME_RST;
      relay_inv_r   <= RELAY_INV_RST;
      mode_r        <= MODE_IDLE;
      running_r     <= 1'b0;
      elapsed_r     <= '0;
      target_r      <= '0;
      cur_vol_r     <= '0;
      vol_sum_r     <= '0;
      dose_cnt_r    <= '0;
      runtime_sum_r <= '0;
      status_r      <= ST_OK;
      finished_r    <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cmd_r         <= cmd_nxt;
      mode_r        <= mode_nxt;
      running_r     <= running_nxt;
      elapsed_r     <= elapsed_nxt;
      target_r      <= target_nxt;
      cur_vol_r     <= cur_vol_nxt;
      vol_sum_r     <= vol_sum_nxt;
      dose_cnt_r    <= dose_cnt_nxt;
      runtime_sum_r <= runtime_sum_nxt;
      status_r      <= status_nxt;
      finished_r    <= finished_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FLOW_RATE:   flow_rate_r   <= cfg_data[FLOW_W-1:0];
          CFG_MAX_RUNTIME: max_runtime_r <= cfg_data[RUNTIME_W-1:0];
          CFG_RELAY_INV:   relay_inv_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    vol_r      <= vol_nxt;
    ovr_r      <= ovr_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

endmodule

// ----- verif/tb_dosing_pump_controller_core.sv -----
// Self-checking testbench of the dosing pump controller core.
`timescale 1ns / 1ps

// The bench drives commands on the in_ stream and compares every result
// transfer, field by field, against a cycle-free predictor of the controller
// that keeps its own copy of the pump state, the totals and the registers.
// The run has three kinds of part:
//   - an opening script with reset defaults that walks every command, the
//     field extremes and each status code, with the obvious answers typed in;
//   - a safety-limit part at a very short runtime limit and the highest flow;
//   - random parts under extreme and random register settings, built mostly
//     from well-formed dose and continuous runs with some noise mixed in.
// Registers are only written once every outstanding result has arrived and
// the sequencer has had time to settle.
// The sender works in bursts with random gaps; the receiver stalls on a
// pattern of its own and, once, holds off long enough to fill the core.

module tb_dosing_pump_controller_core;
  import dpc_pkg::*;

  localparam int SETTLE_CYCLES = 60;     // longer than the slowest command
  localparam int QUIET_LIMIT   = 5000;   // cycles without any transfer
  localparam int LONG_HOLD     = 600;    // one long receiver hold-off
  localparam int HOLD_AFTER    = 300;    // results seen before that hold-off
  localparam int SCRIPT_LEN    = 25;
  localparam int RANDOM_ITEMS  = 160;    // least number of commands in each random part

  localparam longint unsigned TOTAL_CAP = (64'd1 << TOTAL_W) - 64'd1;
  localparam longint unsigned COUNT_CAP = (64'd1 << COUNT_W) - 64'd1;

  // One result transfer, laid out so that a cast from out_tdata lines up:
  // the last member sits in the lowest bits.
  typedef struct packed {
    logic                 finished;
    logic [TOTAL_W-1:0]   runtime_ms;
    logic [COUNT_W-1:0]   doses;
    logic [TOTAL_W-1:0]   volume;
    logic [RUNVOL_W-1:0]  run_vol;
    logic [ELAPSED_W-1:0] elapsed;
    mode_t                mode;
    logic                 pumping;
    logic                 relay;
    status_t              status;
  } pump_result_t;

  // One row of the opening script. Rows with known_answer set carry the
  // status, pump state and mode that must come back.
  typedef struct {
    cmd_t             cmd;
    logic [VOL_W-1:0] vol;
    logic [RATE_W-1:0] rate;
    bit               known_answer;
    status_t          status;
    logic             pumping;
    mode_t            mode;
  } script_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  logic [1:0]              in_tuser = '0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // Predictor copy of the registers and the pump state.
  logic [FLOW_W-1:0]       cfg_flow  = FLOW_RATE_RST;
  logic [RUNTIME_W-1:0]    cfg_limit = MAX_RUNTIME_RST;
  logic                    cfg_inv   = RELAY_INV_RST;
  mode_t                   pump_mode = MODE_IDLE;
  logic                    pump_on = 1'b0;
  logic [ELAPSED_W-1:0]    run_ms = '0;
  logic [ELAPSED_W-1:0]    dose_target = '0;
  logic [RUNVOL_W-1:0]     run_vol = '0;
  logic [TOTAL_W-1:0]      vol_total = '0;
  logic [COUNT_W-1:0]      dose_tally = '0;
  logic [TOTAL_W-1:0]      ms_total = '0;

  pump_result_t            pending_results [$];
  int                      mismatches = 0;
  int                      results_seen = 0;
  int                      burst_left = 0;
  int                      quiet_cycles = 0;

  // Receiver pattern state.
  int                      hold_left = 0;
  bit                      hold_done = 1'b0;
  int                      style_cycles = 0;
  logic [1:0]              stall_style = 2'd0;

  script_row_t opening_script [SCRIPT_LEN] = '{
    // Idle tick and idle stop change nothing.
    '{CMD_TICK,  17'd0,      14'd0,     1'b1, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_STOP,  17'd0,      14'd0,     1'b1, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_DOSE,  17'd0,      14'd0,     1'b1, ST_BAD_VOLUME, 1'b0, MODE_IDLE},
    // Largest volume at the lowest rate is far beyond the runtime limit.
    '{CMD_DOSE,  17'd100000, 14'd10,    1'b1, ST_OVER_LIMIT, 1'b0, MODE_IDLE},
    // Largest volume at the configured rate: a 25 s dose.
    '{CMD_DOSE,  17'd100000, 14'd0,     1'b1, ST_OK,         1'b1, MODE_DOSE},
    '{CMD_DOSE,  17'd1,      14'd0,     1'b1, ST_BUSY,       1'b1, MODE_DOSE},
    '{CMD_START, 17'd0,      14'd0,     1'b1, ST_BUSY,       1'b1, MODE_DOSE},
    '{CMD_TICK,  17'd0,      14'd0,     1'b0, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_TICK,  17'd0,      14'd0,     1'b0, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_TICK,  17'd0,      14'd0,     1'b0, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_STOP,  17'd0,      14'd0,     1'b1, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_START, 17'd0,      14'd0,     1'b1, ST_OK,         1'b1, MODE_CONT},
    '{CMD_TICK,  17'd0,      14'd0,     1'b0, ST_OK,         1'b0, MODE_IDLE},
    // Busy is reported before the volume is looked at.
    '{CMD_DOSE,  17'd0,      14'd0,     1'b1, ST_BUSY,       1'b1, MODE_CONT},
    '{CMD_STOP,  17'd0,      14'd0,     1'b1, ST_OK,         1'b0, MODE_IDLE},
    // Duration rounds down to zero: the dose only ends by stop.
    '{CMD_DOSE,  17'd4,      14'd10000, 1'b1, ST_OK,         1'b1, MODE_DOSE},
    '{CMD_TICK,  17'd0,      14'd0,     1'b0, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_TICK,  17'd0,      14'd0,     1'b0, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_STOP,  17'd0,      14'd0,     1'b1, ST_OK,         1'b0, MODE_IDLE},
    // A 3 ms dose at the highest rate completes on its third tick.
    '{CMD_DOSE,  17'd30,     14'd10000, 1'b1, ST_OK,         1'b1, MODE_DOSE},
    '{CMD_TICK,  17'd0,      14'd0,     1'b0, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_TICK,  17'd0,      14'd0,     1'b0, ST_OK,         1'b0, MODE_IDLE},
    '{CMD_TICK,  17'd0,      14'd0,     1'b1, ST_OK,         1'b0, MODE_IDLE},
    // Duration exactly at the limit is still accepted.
    '{CMD_DOSE,  17'd2400,   14'd40,    1'b1, ST_OK,         1'b1, MODE_DOSE},
    '{CMD_STOP,  17'd0,      14'd0,     1'b1, ST_OK,         1'b0, MODE_IDLE}
  };

  dosing_pump_controller_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned sat_add(input longint unsigned a,
                                              input longint unsigned b,
                                              input longint unsigned cap);
    longint unsigned s;
    s = a + b;
    return (s > cap) ? cap : s;
  endfunction

  // Run volume always follows the configured flow, whatever rate the dose
  // was timed with.
  function automatic logic [RUNVOL_W-1:0] volume_now();
    longint unsigned v;
    v = 64'(run_ms);
    v = (v * 64'(cfg_flow)) / 64'(MS_PER_S);
    return (v > {RUNVOL_W{1'b1}}) ? {RUNVOL_W{1'b1}} : v[RUNVOL_W-1:0];
  endfunction

  // Ends a run; the run time is always added, volume only by the caller.
  function automatic void stop_run();
    ms_total    = TOTAL_W'(sat_add(64'(ms_total), 64'(run_ms), TOTAL_CAP));
    pump_on     = 1'b0;
    pump_mode   = MODE_IDLE;
    dose_target = '0;
  endfunction

  // Advances the predicted pump by one command and returns its result.
  function automatic pump_result_t predict_pump(input cmd_t c,
                                                input logic [VOL_W-1:0] vol,
                                                input logic [RATE_W-1:0] ovr);
    pump_result_t    r;
    status_t         st;
    longint unsigned rate;
    longint unsigned dur;
    logic            done;
    st   = ST_OK;
    done = 1'b0;
    case (c)
      CMD_TICK: begin
        if (pump_on) begin
          if (run_ms != {ELAPSED_W{1'b1}}) run_ms = run_ms + 1'b1;
          run_vol = volume_now();
          // The safety limit wins over a dose reaching its duration.
          if (run_ms >= cfg_limit) begin
            stop_run();
          end else if (pump_mode == MODE_DOSE && dose_target != 0 &&
                       run_ms >= dose_target) begin
            vol_total  = TOTAL_W'(sat_add(64'(vol_total), 64'(run_vol), TOTAL_CAP));
            dose_tally = COUNT_W'(sat_add(64'(dose_tally), 64'd1, COUNT_CAP));
            stop_run();
            done = 1'b1;
          end
        end
      end
      CMD_DOSE: begin
        if (pump_on) begin
          st = ST_BUSY;
        end else if (vol == 0) begin
          st = ST_BAD_VOLUME;
        end else begin
          rate = (ovr != 0) ? 64'(ovr) : 64'(cfg_flow);
          dur  = 64'(vol);
          dur  = (rate != 0) ? (dur * 64'(MS_PER_S)) / rate : 64'd0;
          if (dur > cfg_limit) begin
            st = ST_OVER_LIMIT;
          end else begin
            pump_mode   = MODE_DOSE;
            dose_target = dur[ELAPSED_W-1:0];
            run_vol     = '0;
            run_ms      = '0;
            pump_on     = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (pump_on) begin
          st = ST_BUSY;
        end else begin
          pump_mode   = MODE_CONT;
          dose_target = '0;
          run_vol     = '0;
          run_ms      = '0;
          pump_on     = 1'b1;
        end
      end
      default: begin
        if (pump_on) begin
          run_vol   = volume_now();
          vol_total = TOTAL_W'(sat_add(64'(vol_total), 64'(run_vol), TOTAL_CAP));
          if (pump_mode == MODE_DOSE) begin
            dose_tally = COUNT_W'(sat_add(64'(dose_tally), 64'd1, COUNT_CAP));
          end
          stop_run();
        end
      end
    endcase
    r.status     = st;
    r.relay      = pump_on ^ cfg_inv;
    r.pumping    = pump_on;
    r.mode       = pump_mode;
    r.elapsed    = pump_on ? run_ms : '0;
    r.run_vol    = run_vol;
    r.volume     = vol_total;
    r.doses      = dose_tally;
    r.runtime_ms = ms_total;
    r.finished   = done;
    return r;
  endfunction

  // Offers one command, waits for its transfer and records the prediction.
  // Bursts of back-to-back commands alternate with random gaps.
  task automatic push_cmd(input cmd_t c, input logic [VOL_W-1:0] v,
                          input logic [RATE_W-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {1'b0, r, v};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    pending_results.insert(pending_results.size(), predict_pump(c, v, r));
  endtask

  // Writes all three registers once the core has drained and gone quiet.
  task automatic apply_settings(input logic [FLOW_W-1:0] flow,
                                input logic [RUNTIME_W-1:0] limit,
                                input logic inv);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FLOW_RATE;
    cfg_data  <= CFG_DATA_W'(flow);
    do @(posedge clk); while (!cfg_ready);
    cfg_flow = flow;
    cfg_index <= CFG_MAX_RUNTIME;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_limit = limit;
    cfg_index <= CFG_RELAY_INV;
    cfg_data  <= CFG_DATA_W'(inv);
    do @(posedge clk); while (!cfg_ready);
    cfg_inv = inv;
    cfg_valid <= 1'b0;
  endtask

  // Random traffic. Most of it is complete runs (a short dose left to finish
  // or stopped, a continuous run mostly ended by stop) so the run and total logic
  // gets exercised; the rest is raw noise, lone stops and tick trains.
  task automatic random_traffic(input int n_items);
    int              sent;
    int              kind;
    int              n;
    logic [RATE_W-1:0] r;
    longint unsigned eff;
    longint unsigned v;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // Aim for a dose of up to 25 ms at the chosen rate.
        r   = ($urandom_range(0, 1) == 0) ? '0 : RATE_W'($urandom_range(10, 10000));
        eff = (r != 0) ? 64'(r) : 64'(cfg_flow);
        v   = (64'($urandom_range(0, 25)) * eff) / 64'(MS_PER_S) +
              64'($urandom_range(0, 1));
        if (v == 0) v = 1;
        push_cmd(CMD_DOSE, v[VOL_W-1:0], r);
        n = $urandom_range(0, 30);
        repeat (n) push_cmd(CMD_TICK, VOL_W'($urandom), RATE_W'($urandom));
        sent += n + 1;
        if ($urandom_range(0, 9) < 7) begin
          push_cmd(CMD_STOP, '0, '0);
          sent++;
        end
      end else if (kind <= 5) begin
        push_cmd(CMD_START, VOL_W'($urandom), RATE_W'($urandom));
        n = $urandom_range(0, 20);
        repeat (n) push_cmd(CMD_TICK, '0, '0);
        sent += n + 1;
        if ($urandom_range(0, 4) != 0) begin
          push_cmd(CMD_STOP, '0, '0);
          sent++;
        end
      end else if (kind <= 7) begin
        push_cmd(cmd_t'($urandom_range(0, 3)), VOL_W'($urandom_range(0, 100000)),
                 RATE_W'($urandom_range(0, 10000)));
        sent++;
      end else if (kind == 8) begin
        push_cmd(CMD_STOP, '0, '0);
        sent++;
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) push_cmd(CMD_TICK, '0, '0);
        sent += n;
      end
    end
  endtask

  task automatic check_result(input pump_result_t got, input pump_result_t want);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.relay !== want.relay) begin
      $error("relay_level: expected %0d, got %0d", want.relay, got.relay);
      mismatches++;
    end
    if (got.pumping !== want.pumping) begin
      $error("pumping: expected %0d, got %0d", want.pumping, got.pumping);
      mismatches++;
    end
    if (got.mode !== want.mode) begin
      $error("mode_out: expected %0d, got %0d", want.mode, got.mode);
      mismatches++;
    end
    if (got.elapsed !== want.elapsed) begin
      $error("elapsed_out: expected %0d, got %0d", want.elapsed, got.elapsed);
      mismatches++;
    end
    if (got.run_vol !== want.run_vol) begin
      $error("run_volume: expected %0d, got %0d", want.run_vol, got.run_vol);
      mismatches++;
    end
    if (got.volume !== want.volume) begin
      $error("total_volume: expected %0d, got %0d", want.volume, got.volume);
      mismatches++;
    end
    if (got.doses !== want.doses) begin
      $error("dose_total: expected %0d, got %0d", want.doses, got.doses);
      mismatches++;
    end
    if (got.runtime_ms !== want.runtime_ms) begin
      $error("total_runtime: expected %0d, got %0d", want.runtime_ms, got.runtime_ms);
      mismatches++;
    end
    if (got.finished !== want.finished) begin
      $error("dose_finished: expected %0d, got %0d", want.finished, got.finished);
      mismatches++;
    end
  endtask

  // Result checker: every result transfer is matched with the oldest
  // outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatches++;
      end else begin
        check_result(pump_result_t'(out_tdata), pending_results.pop_front());
      end
    end
  end

  // Receiver: switches between randomly chosen stall styles, from always
  // ready to mostly stalled, and once holds off for a long stretch
  // while the sender keeps offering, so the result register and the
  // sequencer fill up and in_tready drops.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (style_cycles == 0) begin
        stall_style  <= 2'($urandom_range(0, 3));
        style_cycles <= $urandom_range(20, 200);
      end else begin
        style_cycles <= style_cycles - 1;
      end
      case (stall_style)
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= 1'($urandom_range(0, 1));
        2'd2: out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Watchdog: a stretch with no transfer on any channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pump_result_t want;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Opening script at the reset register values.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      push_cmd(opening_script[i].cmd, opening_script[i].vol, opening_script[i].rate);
      if (opening_script[i].known_answer) begin
        want         = pending_results[pending_results.size() - 1];
        want.status  = opening_script[i].status;
        want.pumping = opening_script[i].pumping;
        want.mode    = opening_script[i].mode;
        pending_results[pending_results.size() - 1] = want;
      end
    end

    // Very short runtime limit, highest flow, plain relay polarity. A
    // continuous run and a dose timed exactly at the limit are both cut off
    // by the safety limit, so the dose adds run time but no volume.
    apply_settings(14'd10000, 19'd40, 1'b0);
    push_cmd(CMD_START, '0, '0);
    repeat (40) push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_DOSE, 17'd40, 14'd1000);
    repeat (40) push_cmd(CMD_TICK, '0, '0);
    push_cmd(CMD_DOSE, 17'd10010, 14'd10000);

    // Lowest flow and longest limit, then two random settings. A run may
    // still be going when the registers change; it carries on at the new
    // values.
    apply_settings(14'd10, 19'd300000, 1'b1);
    random_traffic(RANDOM_ITEMS);
    apply_settings(FLOW_W'($urandom_range(10, 10000)),
                   RUNTIME_W'($urandom_range(1000, 300000)), 1'($urandom_range(0, 1)));
    random_traffic(RANDOM_ITEMS);
    apply_settings(FLOW_W'($urandom_range(10, 10000)),
                   RUNTIME_W'($urandom_range(1000, 300000)), 1'($urandom_range(0, 1)));
    random_traffic(RANDOM_ITEMS);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
